FILE: sv/button_dc_motor_pwm_control_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button DC motor PWM control unit
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DC_MOTOR_PWM_CONTROL_UNIT_DEFINES_SVH
`define BUTTON_DC_MOTOR_PWM_CONTROL_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BDMPC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bdmpc: check failed");
`define BDMPC_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("bdmpc: sequence check failed");
`else
`define BDMPC_ASSERT(lbl, prop)
`define BDMPC_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: sv/bdmpc_pkg.sv
// ----------------------------------------------------------------------------
// bdmpc_pkg
// Shared constants and types of the button DC motor PWM control unit.
// ----------------------------------------------------------------------------
package bdmpc_pkg;

    localparam int SPEED_W    = 7;
    localparam int PHASE_W    = 7;
    localparam int DEB_W      = 16;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    localparam logic [SPEED_W-1:0] PWM_RANGE      = 7'd100;
    localparam logic [SPEED_W-1:0] SPEED_RESET    = 7'd50;
    localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = 16'd100;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_HELD = 2'd2
    } t_btn_phase;

    typedef struct packed {
        logic slower;
        logic faster;
        logic dir;
        logic run;
    } t_btn_hits;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_now;
        logic               clockwise;
        logic               running;
        logic               led_n;
        logic               drive_b;
        logic               drive_a;
    } t_result;

endpackage

FILE: sv/button_dc_motor_pwm_control_unit.sv
// ----------------------------------------------------------------------------
// button_dc_motor_pwm_control_unit
// Debounced run, direction and speed buttons driving a PWM DC motor bridge.
// ----------------------------------------------------------------------------
// One input beat is one PWM tick carrying four active-low button levels; each
// beat yields one output beat with the pin levels and the current run state,
// direction and speed. The block takes one beat per clock cycle unless it
// back-pressures the input, and passes each beat through the input register
// and then the result register, with all button and PWM work between them. A
// stalled output holds the result and back-pressures the input only once both
// registers are full. Write the debounce tick count only while no beat is in
// flight.
`include "button_dc_motor_pwm_control_unit_defines.svh"

module button_dc_motor_pwm_control_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bdmpc_pkg::DEB_W-1:0]       i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] run_button_n, [1] direction_button_n, [2] faster_button_n,
    // [3] slower_button_n, [7:4] zero
    input  logic [bdmpc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] drive_a, [1] drive_b, [2] led_n, [3] running, [4] clockwise,
    // [11:5] speed_now, [15:12] zero
    output logic [bdmpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import bdmpc_pkg::*;

    logic             r_in_valid;
    logic [3:0]       r_in_btn;
    logic             r_out_valid;
    t_result          r_out;
    logic [DEB_W-1:0] r_debounce_ticks;

    logic             advance;
    logic             step;
    logic             s_acc;
    t_btn_hits        hits;
    t_result          res;

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = advance && r_in_valid;
    assign s_axis_tready = !r_in_valid || advance;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            r_debounce_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_acc) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_btn <= s_axis_tdata[3:0];
        end
    end

    bdmpc_debounce u_run_btn (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (step),
        .i_level_n (r_in_btn[0]),
        .i_ticks   (r_debounce_ticks),
        .o_hit     (hits.run)
    );

    bdmpc_debounce u_dir_btn (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (step),
        .i_level_n (r_in_btn[1]),
        .i_ticks   (r_debounce_ticks),
        .o_hit     (hits.dir)
    );

    bdmpc_debounce u_up_btn (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (step),
        .i_level_n (r_in_btn[2]),
        .i_ticks   (r_debounce_ticks),
        .o_hit     (hits.faster)
    );

    bdmpc_debounce u_dn_btn (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (step),
        .i_level_n (r_in_btn[3]),
        .i_ticks   (r_debounce_ticks),
        .o_hit     (hits.slower)
    );

    bdmpc_drive u_drive (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step),
        .i_hits  (hits),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_out};

    `BDMPC_ASSERT(a_led_tracks_run, m_axis_tvalid |-> (r_out.led_n == !r_out.running))
    `BDMPC_ASSERT(a_stop_pins_high,
        (m_axis_tvalid && !r_out.running) |-> (r_out.drive_a && r_out.drive_b))
    `BDMPC_ASSERT(a_speed_in_range, m_axis_tvalid |-> (r_out.speed_now <= PWM_RANGE))
    `BDMPC_ASSERT_NEXT(a_step_gives_beat, step, m_axis_tvalid)

endmodule

FILE: sv/bdmpc_debounce.sv
// ----------------------------------------------------------------------------
// bdmpc_debounce
// Per-button press detector: see press, wait, confirm low, act once, wait release.
// ----------------------------------------------------------------------------
`include "button_dc_motor_pwm_control_unit_defines.svh"

module bdmpc_debounce (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_level_n,
    input  logic [bdmpc_pkg::DEB_W-1:0] i_ticks,
    output logic                       o_hit
);
    import bdmpc_pkg::*;

    t_btn_phase       r_phase, n_phase;
    logic [DEB_W-1:0] r_count, n_count;
    logic [DEB_W-1:0] count_inc;
    logic             low;

    assign low       = !i_level_n;
    assign count_inc = r_count + 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        o_hit   = 1'b0;
        case (r_phase)
            PH_WAIT: begin
                n_count = count_inc;
                if (count_inc >= i_ticks) begin
                    if (low) begin
                        n_phase = PH_HELD;
                        o_hit   = 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_HELD: begin
                if (!low) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                if (low) begin
                    n_count = '0;
                    if (i_ticks == '0) begin
                        n_phase = PH_HELD;
                        o_hit   = 1'b1;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end else begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    `BDMPC_ASSERT(a_held_no_hit, (r_phase == PH_HELD) |-> !o_hit)
    `BDMPC_ASSERT_NEXT(a_hit_then_held, i_en && o_hit, r_phase == PH_HELD)

endmodule

FILE: sv/bdmpc_drive.sv
// ----------------------------------------------------------------------------
// bdmpc_drive
// Run, direction and speed state, PWM phase counter and motor pin levels.
// ----------------------------------------------------------------------------
module bdmpc_drive (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  bdmpc_pkg::t_btn_hits i_hits,
    output bdmpc_pkg::t_result  o_res
);
    import bdmpc_pkg::*;

    logic               r_run, r_dir;
    logic [SPEED_W-1:0] r_speed;
    logic [PHASE_W-1:0] r_phase;

    logic               n_run, n_dir;
    logic [SPEED_W-1:0] n_speed;
    logic [PHASE_W-1:0] n_phase;
    logic [SPEED_W-1:0] speed_up, speed_dn;
    logic [PHASE_W-1:0] phase_cur, phase_inc;

    always_comb begin
        n_run = r_run ^ i_hits.run;
        n_dir = r_dir ^ i_hits.dir;

        speed_up = r_speed;
        if (i_hits.faster) begin
            speed_up = (r_speed < PWM_RANGE) ? r_speed + 1'b1 : PWM_RANGE;
        end
        speed_dn = speed_up;
        if (i_hits.slower) begin
            if (speed_dn > PWM_RANGE) begin
                speed_dn = PWM_RANGE;
            end
            if (speed_dn != '0) begin
                speed_dn = speed_dn - 1'b1;
            end
        end
        n_speed = speed_dn;

        phase_cur = (r_phase >= PWM_RANGE) ? '0 : r_phase;
        phase_inc = phase_cur + 1'b1;
        n_phase   = (phase_inc >= PWM_RANGE) ? '0 : phase_inc;

        o_res.running   = n_run;
        o_res.clockwise = n_dir;
        o_res.speed_now = n_speed;
        if (n_run) begin
            o_res.led_n = 1'b0;
            if (n_dir) begin
                o_res.drive_a = 1'b1;
                o_res.drive_b = (phase_cur < (PWM_RANGE - n_speed));
            end else begin
                o_res.drive_a = 1'b0;
                o_res.drive_b = (phase_cur < n_speed);
            end
        end else begin
            o_res.led_n   = 1'b1;
            o_res.drive_a = 1'b1;
            o_res.drive_b = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b1;
            r_dir   <= 1'b1;
            r_speed <= (SPEED_RESET > PWM_RANGE) ? PWM_RANGE : SPEED_RESET;
            r_phase <= '0;
        end else if (i_en) begin
            r_run   <= n_run;
            r_dir   <= n_dir;
            r_speed <= n_speed;
            r_phase <= n_phase;
        end
    end

endmodule

FILE: tb/sv/button_dc_motor_pwm_control_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_dc_motor_pwm_control_unit_tb
// Streams active-low button ticks through the motor PWM unit and checks every
// output beat against a cycle model of debounce, run/direction toggles, speed
// steps with saturation, and the PWM pin levels, under random flow control
// and several debounce settings.
// ----------------------------------------------------------------------------
module button_dc_motor_pwm_control_unit_tb;
    import bdmpc_pkg::*;

    localparam int RUN_BTN     = 0;
    localparam int DIR_BTN     = 1;
    localparam int FASTER_BTN  = 2;
    localparam int SLOWER_BTN  = 3;
    localparam int LONG_HOLD   = 80;
    localparam int CYCLE_LIMIT = 200000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [DEB_W-1:0]      i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    button_dc_motor_pwm_control_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // motor model state
    logic [DEB_W-1:0] deb_ticks   = DEBOUNCE_RESET;
    logic             run_on      = 1'b1;
    logic             cw_on       = 1'b1;
    int               speed       = int'(SPEED_RESET);
    int               pwm_count   = 0;
    t_btn_phase       btn_phase [4] = '{PH_IDLE, PH_IDLE, PH_IDLE, PH_IDLE};
    logic [DEB_W-1:0] btn_count [4] = '{16'd0, 16'd0, 16'd0, 16'd0};

    logic [3:0] button_ticks [$];
    t_result    due_outputs  [$];

    int  err_count     = 0;
    int  beats_in      = 0;
    int  beats_out     = 0;
    int  presses_acted = 0;
    int  settings_used = 1;
    int  cycles        = 0;
    bit  top_speed_hit = 1'b0;
    bit  zero_speed_hit = 1'b0;

    logic in_beat    = 1'b0;
    int   burst_left = 1;
    int   gap_left   = 0;
    int   flow_left  = 0;
    int   hold_left  = 0;
    int   hold_asks  = 0;
    int   hold_served = 0;

    function automatic bit step_button(int b, logic level);
        bit pressed;
        pressed = (level == 1'b0);
        step_button = 1'b0;
        case (btn_phase[b])
            PH_WAIT: begin
                btn_count[b] = btn_count[b] + 1'b1;
                if (btn_count[b] >= deb_ticks) begin
                    if (pressed) begin
                        btn_phase[b] = PH_HELD;
                        step_button = 1'b1;
                    end else begin
                        btn_phase[b] = PH_IDLE;
                    end
                end
            end
            PH_HELD: begin
                if (!pressed)
                    btn_phase[b] = PH_IDLE;
            end
            default: begin
                if (pressed) begin
                    btn_count[b] = '0;
                    if (deb_ticks == '0) begin
                        btn_phase[b] = PH_HELD;
                        step_button = 1'b1;
                    end else begin
                        btn_phase[b] = PH_WAIT;
                    end
                end else begin
                    btn_phase[b] = PH_IDLE;
                end
            end
        endcase
        if (step_button)
            presses_acted++;
    endfunction

    function automatic t_result motor_tick(logic [3:0] lvl);
        t_result r;
        if (step_button(RUN_BTN, lvl[RUN_BTN]))
            run_on = ~run_on;
        if (step_button(DIR_BTN, lvl[DIR_BTN]))
            cw_on = ~cw_on;
        if (step_button(FASTER_BTN, lvl[FASTER_BTN])) begin
            if (speed < int'(PWM_RANGE))
                speed++;
        end
        if (step_button(SLOWER_BTN, lvl[SLOWER_BTN])) begin
            if (speed > 0)
                speed--;
        end
        if (speed == int'(PWM_RANGE))
            top_speed_hit = 1'b1;
        if (speed == 0)
            zero_speed_hit = 1'b1;
        if (pwm_count >= int'(PWM_RANGE))
            pwm_count = 0;
        r.running   = run_on;
        r.clockwise = cw_on;
        r.speed_now = speed[SPEED_W-1:0];
        r.led_n     = ~run_on;
        if (!run_on) begin
            r.drive_a = 1'b1;
            r.drive_b = 1'b1;
        end else if (cw_on) begin
            r.drive_a = 1'b1;
            r.drive_b = (pwm_count < int'(PWM_RANGE) - speed);
        end else begin
            r.drive_a = 1'b0;
            r.drive_b = (pwm_count < speed);
        end
        pwm_count++;
        if (pwm_count >= int'(PWM_RANGE))
            pwm_count = 0;
        return r;
    endfunction

    // predict on input beats, check output beats
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            in_beat <= 1'b0;
        end else begin
            in_beat <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                due_outputs.push_back(motor_tick(s_axis_tdata[3:0]));
                beats_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                beats_out++;
                got = t_result'(m_axis_tdata[11:0]);
                if (due_outputs.size() == 0) begin
                    $error("unexpected output beat 0x%h", m_axis_tdata);
                    err_count++;
                end else begin
                    want = due_outputs.pop_front();
                    if (got.drive_a !== want.drive_a) begin
                        $error("drive_a: expected %0d, got %0d", want.drive_a, got.drive_a);
                        err_count++;
                    end
                    if (got.drive_b !== want.drive_b) begin
                        $error("drive_b: expected %0d, got %0d", want.drive_b, got.drive_b);
                        err_count++;
                    end
                    if (got.led_n !== want.led_n) begin
                        $error("led_n: expected %0d, got %0d", want.led_n, got.led_n);
                        err_count++;
                    end
                    if (got.running !== want.running) begin
                        $error("running: expected %0d, got %0d", want.running, got.running);
                        err_count++;
                    end
                    if (got.clockwise !== want.clockwise) begin
                        $error("clockwise: expected %0d, got %0d",
                               want.clockwise, got.clockwise);
                        err_count++;
                    end
                    if (got.speed_now !== want.speed_now) begin
                        $error("speed_now: expected %0d, got %0d",
                               want.speed_now, got.speed_now);
                        err_count++;
                    end
                end
            end
        end
    end

    // sender: bursts with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else if (!s_axis_tvalid || in_beat) begin
            if (gap_left > 0) begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (button_ticks.size() != 0) begin
                s_axis_tdata  <= {4'b0000, button_ticks.pop_front()};
                s_axis_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern plus long hold-offs on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_asks != hold_served) begin
            hold_served   <= hold_served + 1;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (flow_left > 0) begin
            flow_left     <= flow_left - 1;
            m_axis_tready <= 1'b1;
        end else begin
            flow_left     <= $urandom_range(0, 30);
            hold_left     <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            m_axis_tready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("button_dc_motor_pwm_control_unit regression: fail");
            $finish;
        end
    end

    // press/release sequences on the buttons in busy, with sparse level noise
    task automatic queue_ticks(int n, int hold_lo, int hold_hi, int rel_hi,
                               logic [3:0] busy);
        int         left [4];
        logic [3:0] lvl;
        logic [3:0] beat;
        lvl = 4'hF;
        for (int b = 0; b < 4; b++)
            left[b] = 0;
        for (int k = 0; k < n; k++) begin
            for (int b = 0; b < 4; b++) begin
                if (busy[b]) begin
                    if (left[b] == 0) begin
                        if (lvl[b] == 1'b0) begin
                            lvl[b]  = 1'b1;
                            left[b] = $urandom_range(1, rel_hi);
                        end else begin
                            lvl[b]  = 1'b0;
                            left[b] = $urandom_range(hold_lo, hold_hi);
                        end
                    end
                    left[b]--;
                end
            end
            beat = lvl;
            if ($urandom_range(0, 19) == 0)
                beat = beat ^ (busy & (4'b0001 << $urandom_range(0, 3)));
            button_ticks.push_back(beat);
        end
    endtask

    task automatic drain();
        while (button_ticks.size() != 0 || s_axis_tvalid || due_outputs.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_debounce(logic [DEB_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        deb_ticks = value;
        settings_used++;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset debounce, presses around the confirm point, one long hold-off
        hold_asks++;
        queue_ticks(200, 60, 120, 3, 4'hF);

        // zero debounce: each button alone, all together, faster with slower
        write_debounce(16'd0);
        foreach (button_ticks[i]) ;
        button_ticks.push_back(4'hF);
        button_ticks.push_back(4'hE);
        button_ticks.push_back(4'hF);
        button_ticks.push_back(4'hD);
        button_ticks.push_back(4'hF);
        button_ticks.push_back(4'hB);
        button_ticks.push_back(4'hF);
        button_ticks.push_back(4'h7);
        button_ticks.push_back(4'hF);
        button_ticks.push_back(4'h0);
        button_ticks.push_back(4'h0);
        button_ticks.push_back(4'hF);
        button_ticks.push_back(4'h3);
        button_ticks.push_back(4'h3);
        button_ticks.push_back(4'hF);
        button_ticks.push_back(4'hE);
        button_ticks.push_back(4'hF);

        // saturate speed at the top, then at zero
        queue_ticks(130, 1, 1, 1, 4'b0100);
        queue_ticks(210, 1, 1, 1, 4'b1000);

        write_debounce(16'd1);
        hold_asks++;
        queue_ticks(60, 1, 4, 3, 4'hF);

        // leave presses mid-wait, then lower the count under them
        write_debounce(16'hFFFF);
        queue_ticks(20, 3, 10, 2, 4'hF);
        write_debounce(16'd3);
        queue_ticks(60, 1, 6, 3, 4'hF);

        drain();
        repeat (8) @(posedge i_clk);
        $display("covered %0d tick beats in, %0d out, %0d debounce settings (0 to 65535)",
                 beats_in, beats_out, settings_used);
        $display("acted on %0d presses, speed top reached %0d, speed zero reached %0d",
                 presses_acted, top_speed_hit, zero_speed_hit);
        if (err_count == 0)
            $display("button_dc_motor_pwm_control_unit regression: pass");
        else
            $display("button_dc_motor_pwm_control_unit regression: fail");
        $finish;
    end

endmodule
